// ----- design/assert_macros.svh -----
// assertion macros shared by the stack modules
// no dependencies; included by files that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ----- design/bls_pkg.sv -----
// shared types and constants for the bounded lifo stack
// no dependencies; used by bls_ctrl, bls_dp and bounded_lifo_stack
package bls_pkg;

    localparam int DEPTH_DEFAULT = 64;
    localparam int CNT_W = 7;
    localparam int DATA_W = 32;

    localparam logic [CNT_W-1:0] CAPACITY_RESET = 7'd64;
    localparam logic [DATA_W-1:0] NO_VALUE = 32'hFFFF_FFFF;

    localparam logic [1:0] ACT_PUSH = 2'd0;
    localparam logic [1:0] ACT_POP = 2'd1;
    localparam logic [1:0] ACT_PEEK = 2'd2;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_OVERFLOW = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;
    localparam logic [1:0] ST_BADPOS = 2'd3;

    typedef enum logic
    {
        S_IDLE,
        S_DONE
    } state_t;

    typedef struct packed
    {
        logic execute;
        logic mem_wr;
        logic mem_rd;
    } ctrl_cmd_t;

    typedef struct packed
    {
        logic write_ok;
        logic read_ok;
    } dp_status_t;

endpackage

// ----- design/bls_ctrl.sv -----
// controller state machine for the bounded lifo stack
// depends on bls_pkg and assert_macros.svh
`include "assert_macros.svh"

module bls_ctrl
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    output logic                   out_valid,
    input  logic                   out_stall,
    input  bls_pkg::dp_status_t    dp_status,
    output bls_pkg::ctrl_cmd_t     cmd
);

    bls_pkg::state_t state_reg;
    bls_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bls_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bls_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = bls_pkg::S_DONE;
                end
            end
            bls_pkg::S_DONE:
            begin
                if (!out_stall)
                begin
                    state_next = bls_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = bls_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall = 1'b1;
        out_valid = 1'b0;
        cmd = '0;
        unique case (state_reg)
            bls_pkg::S_IDLE:
            begin
                in_stall = 1'b0;
                cmd.execute = in_valid;
                cmd.mem_wr = in_valid && dp_status.write_ok;
                cmd.mem_rd = in_valid && dp_status.read_ok;
            end
            bls_pkg::S_DONE:
            begin
                out_valid = 1'b1;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    `ASSERT_SAME(a_no_accept_while_result, clk, rst_n, out_valid, in_stall)
    `ASSERT_NEXT(a_accept_gives_result, clk, rst_n, in_valid && !in_stall, out_valid)
    `ASSERT_SAME(a_wr_rd_exclusive, clk, rst_n, cmd.mem_wr, !cmd.mem_rd)

endmodule

// ----- design/bls_dp.sv -----
// datapath for the bounded lifo stack: storage, fill count, capacity, result
// depends on bls_pkg and assert_macros.svh
`include "assert_macros.svh"

module bls_dp
#(
    parameter int DEPTH = bls_pkg::DEPTH_DEFAULT
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [bls_pkg::CNT_W-1:0]     cfg_wr_data,
    input  logic [1:0]                    action,
    input  logic signed [bls_pkg::DATA_W-1:0] push_value,
    input  logic [bls_pkg::CNT_W-1:0]     peek_position,
    input  bls_pkg::ctrl_cmd_t            cmd,
    output bls_pkg::dp_status_t           dp_status,
    output logic signed [bls_pkg::DATA_W-1:0] data,
    output logic [1:0]                    status,
    output logic                          is_empty,
    output logic                          is_full,
    output logic [bls_pkg::CNT_W-1:0]     entry_count
);

    localparam int CW = bls_pkg::CNT_W;
    localparam int DW = bls_pkg::DATA_W;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    logic [CW-1:0] capacity_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [1:0]    status_reg;
    logic [1:0]    status_next;
    logic          use_mem_reg;

    logic [CW-1:0] cap_eff;
    logic [CW-1:0] slot;
    logic [AW-1:0] mem_addr;

    // effective capacity saturates at the storage depth
    always_comb
    begin
        if ({{(32-CW){1'b0}}, capacity_reg} > 32'(DEPTH))
        begin
            cap_eff = CW'(DEPTH);
        end
        else
        begin
            cap_eff = capacity_reg;
        end
    end

    always_comb
    begin
        dp_status = '0;
        count_next = count_reg;
        status_next = bls_pkg::ST_OK;
        slot = count_reg;
        unique case (action)
            bls_pkg::ACT_PUSH:
            begin
                slot = count_reg;
                if (count_reg < cap_eff)
                begin
                    dp_status.write_ok = 1'b1;
                    count_next = count_reg + CW'(1);
                end
                else
                begin
                    status_next = bls_pkg::ST_OVERFLOW;
                end
            end
            bls_pkg::ACT_POP:
            begin
                slot = count_reg - CW'(1);
                if (count_reg != '0)
                begin
                    dp_status.read_ok = 1'b1;
                    count_next = count_reg - CW'(1);
                end
                else
                begin
                    status_next = bls_pkg::ST_UNDERFLOW;
                end
            end
            bls_pkg::ACT_PEEK:
            begin
                slot = count_reg - peek_position;
                if (peek_position != '0 && peek_position <= count_reg)
                begin
                    dp_status.read_ok = 1'b1;
                end
                else
                begin
                    status_next = bls_pkg::ST_BADPOS;
                end
            end
            default:
            begin
                status_next = bls_pkg::ST_OK;
            end
        endcase
    end

    assign mem_addr = AW'(slot);

    // single-port storage, read data registered
    always_ff @(posedge clk)
    begin
        if (cmd.mem_wr)
        begin
            mem[mem_addr] <= push_value;
        end
        if (cmd.mem_rd)
        begin
            rd_data_reg <= mem[mem_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= bls_pkg::CAPACITY_RESET;
            count_reg <= '0;
            status_reg <= bls_pkg::ST_OK;
            use_mem_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                capacity_reg <= cfg_wr_data;
            end
            if (cmd.execute)
            begin
                count_reg <= count_next;
                status_reg <= status_next;
                use_mem_reg <= dp_status.read_ok;
            end
        end
    end

    assign data = use_mem_reg ? rd_data_reg : bls_pkg::NO_VALUE;
    assign status = status_reg;
    assign is_empty = (count_reg == '0);
    assign is_full = (count_reg >= cap_eff);
    assign entry_count = count_reg;

    `ASSERT_SAME(a_count_in_depth, clk, rst_n, 1'b1, 32'(count_reg) <= 32'(DEPTH))
    `ASSERT_NEXT(a_push_grows, clk, rst_n, cmd.mem_wr, count_reg == $past(count_reg) + CW'(1))
    `ASSERT_NEXT(a_fail_keeps_count, clk, rst_n,
        cmd.execute && status_next != bls_pkg::ST_OK, $stable(count_reg))

endmodule

// ----- design/bounded_lifo_stack.sv -----
// bounded lifo stack of signed 32-bit words: push, pop and peek
// top level; depends on bls_pkg, bls_ctrl and bls_dp
//
// usage:
//   input channel (in_valid / in_stall) carries action, push_value and
//   peek_position; a transaction is taken when in_valid is high and in_stall
//   is low. output channel (out_valid / out_stall) carries data, status,
//   is_empty, is_full and entry_count, one result per input transaction.
//   capacity is written through cfg_wr_en / cfg_wr_data while idle.
// result timing:
//   the result is valid the cycle after the input transaction; one item is
//   in flight at a time, since the controller holds in_stall high while a
//   result waits.
// reset:
//   rst_n clears the fill count and sets capacity to 64; storage contents
//   are not cleared and need no clearing pass.
// stall:
//   while out_stall is high the result holds and in_stall stays high.

module bounded_lifo_stack
#(
    parameter int DEPTH = bls_pkg::DEPTH_DEFAULT
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [bls_pkg::CNT_W-1:0]         cfg_wr_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [1:0]                        action,
    input  logic signed [bls_pkg::DATA_W-1:0] push_value,
    input  logic [bls_pkg::CNT_W-1:0]         peek_position,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [bls_pkg::DATA_W-1:0] data,
    output logic [1:0]                        status,
    output logic                              is_empty,
    output logic                              is_full,
    output logic [bls_pkg::CNT_W-1:0]         entry_count
);

    bls_pkg::ctrl_cmd_t  cmd;
    bls_pkg::dp_status_t dp_status;

    bls_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .dp_status (dp_status),
        .cmd       (cmd)
    );

    bls_dp
    #(
        .DEPTH (DEPTH)
    )
    u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .action        (action),
        .push_value    (push_value),
        .peek_position (peek_position),
        .cmd           (cmd),
        .dp_status     (dp_status),
        .data          (data),
        .status        (status),
        .is_empty      (is_empty),
        .is_full       (is_full),
        .entry_count   (entry_count)
    );

endmodule
